[hdl/i2c_byte_master_engine_core_defines.svh]
// Assertion macros for the I2C byte master engine.
`ifndef I2C_BYTE_MASTER_ENGINE_CORE_DEFINES_SVH
`define I2C_BYTE_MASTER_ENGINE_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define IBME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the clock cycle after the antecedent.
`define IBME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ibme_pkg.sv]
// Types and constants shared by the I2C byte master engine modules.
package ibme_pkg;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdStop  = 2'd1,
    CmdWrite = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef enum logic {
    ItemCmd  = 1'b0,
    ItemTick = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       more_to_read;
    logic       sda_in;
  } item_t;

  localparam int unsigned IbmeQueueDepth = 2;

  localparam logic [4:0] StepWriteAck  = 5'd24;
  localparam logic [4:0] StepWriteScl  = 5'd25;
  localparam logic [4:0] StepReadBits  = 5'd16;
  localparam logic [4:0] StepReadAns   = 5'd17;
  localparam logic [4:0] StepReadScl   = 5'd18;
  localparam logic [4:0] StepMax       = 5'd27;

  localparam logic [1:0] PhaseData = 2'd0;
  localparam logic [1:0] PhaseHigh = 2'd1;
  localparam logic [1:0] PhaseLow  = 2'd2;

endpackage

[hdl/ibme_front.sv]
// Front end: classifies incoming words and strips fields a command does not use.
module ibme_front import ibme_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [1:0] command_i,
  input  logic [7:0] tx_byte_i,
  input  logic       more_to_read_i,
  input  logic       sda_in_i,
  output logic       push_o,
  input  logic       queue_ready_i,
  output item_t      item_o
);

  cmd_e cmd;

  assign cmd        = cmd_e'(command_i);
  assign push_o     = in_valid_i & queue_ready_i;
  assign in_ready_o = queue_ready_i;

  always_comb begin
    item_o              = '0;
    item_o.kind         = req_type_i ? ItemTick : ItemCmd;
    item_o.cmd          = cmd;
    item_o.tx_byte      = 8'h00;
    item_o.more_to_read = 1'b0;
    item_o.sda_in       = 1'b0;
    if (req_type_i) begin
      item_o.sda_in = sda_in_i;
    end else begin
      case (cmd)
        CmdWrite: item_o.tx_byte = tx_byte_i;
        CmdRead:  item_o.more_to_read = more_to_read_i;
        default:  ;
      endcase
    end
  end

endmodule

[hdl/ibme_queue.sv]
// Short word queue between the front end and the pin sequencer.
module ibme_queue import ibme_pkg::*; #(
  parameter int unsigned Depth = IbmeQueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntFull);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/ibme_back.sv]
// Back end: runs the SCL/SDA pin sequence one step per tick and holds the result word.
module ibme_back import ibme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       cmd_done_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_seen_o,
  output logic       cmd_rejected_o
);

  `include "i2c_byte_master_engine_core_defines.svh"

  logic [4:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  cmd_e       active_q, active_d;
  logic       busy_q, busy_d;
  logic [7:0] shift_q, shift_d;
  logic       nack_q, nack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] rx_q, rx_d;
  logic       ack_q, ack_d;
  logic       done_q, done_d;
  logic       rej_q, rej_d;
  logic       out_valid_q;
  logic       take;
  logic       last;

  assign take  = item_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o = take;

  always_comb begin
    step_d   = step_q;
    phase_d  = phase_q;
    active_d = active_q;
    busy_d   = busy_q;
    shift_d  = shift_q;
    nack_d   = nack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    ack_d    = ack_q;
    done_d   = 1'b0;
    rej_d    = 1'b0;
    last     = 1'b0;
    if (item_i.kind == ItemCmd) begin
      if (busy_q) begin
        rej_d = 1'b1;
      end else begin
        active_d = item_i.cmd;
        busy_d   = 1'b1;
        step_d   = '0;
        phase_d  = PhaseData;
        case (item_i.cmd)
          CmdWrite: shift_d = item_i.tx_byte;
          CmdRead: begin
            shift_d = 8'h00;
            nack_d  = ~item_i.more_to_read;
          end
          default: ;
        endcase
      end
    end else if (busy_q) begin
      case (active_q)
        CmdStart: begin
          case (step_q)
            5'd0:    sda_d = 1'b1;
            5'd1:    scl_d = 1'b1;
            5'd2:    sda_d = 1'b0;
            default: begin
              scl_d = 1'b0;
              last  = 1'b1;
            end
          endcase
        end
        CmdStop: begin
          case (step_q)
            5'd0:    sda_d = 1'b0;
            5'd1:    scl_d = 1'b1;
            default: begin
              sda_d = 1'b1;
              last  = 1'b1;
            end
          endcase
        end
        CmdWrite: begin
          if (step_q < StepWriteAck) begin
            phase_d = (phase_q == PhaseLow) ? PhaseData : phase_q + 1'b1;
            case (phase_q)
              PhaseData: sda_d = shift_q[7];
              PhaseHigh: scl_d = 1'b1;
              default: begin
                scl_d   = 1'b0;
                shift_d = {shift_q[6:0], 1'b0};
              end
            endcase
          end else if (step_q == StepWriteAck) begin
            sda_d = 1'b1;
          end else if (step_q == StepWriteScl) begin
            scl_d = 1'b1;
          end else begin
            ack_d = item_i.sda_in;
            scl_d = 1'b0;
            last  = 1'b1;
          end
        end
        default: begin
          if (step_q == '0) begin
            sda_d = 1'b1;
          end else if (step_q <= StepReadBits) begin
            if (step_q[0]) begin
              scl_d = 1'b1;
            end else begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              scl_d   = 1'b0;
            end
          end else if (step_q == StepReadAns) begin
            sda_d = nack_q;
          end else if (step_q == StepReadScl) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            rx_d  = shift_q;
            last  = 1'b1;
          end
        end
      endcase
      step_d = step_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      phase_q     <= PhaseData;
      active_q    <= CmdStart;
      busy_q      <= 1'b0;
      shift_q     <= '0;
      nack_q      <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_q        <= '0;
      ack_q       <= 1'b1;
      done_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        step_q   <= step_d;
        phase_q  <= phase_d;
        active_q <= active_d;
        busy_q   <= busy_d;
        shift_q  <= shift_d;
        nack_q   <= nack_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        rx_q     <= rx_d;
        ack_q    <= ack_d;
        done_q   <= done_d;
        rej_q    <= rej_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_out_o      = scl_q;
  assign sda_out_o      = sda_q;
  assign busy_res_o     = busy_q;
  assign cmd_done_o     = done_q;
  assign rx_byte_o      = rx_q;
  assign ack_seen_o     = ack_q;
  assign cmd_rejected_o = rej_q;

  `IBME_ASSERT(a_step_range, !busy_q || step_q < StepMax, "step count past end of sequence")
  `IBME_ASSERT(a_done_not_busy, !done_q || (!busy_q && !rej_q), "done word still busy or rejected")
  `IBME_ASSERT_NEXT(a_idle_tick, take && item_i.kind == ItemTick && !busy_q, scl_q == $past(scl_q) && sda_q == $past(sda_q), "idle tick moved a pin")
  `IBME_ASSERT_NEXT(a_reject_holds, take && item_i.kind == ItemCmd && busy_q, busy_q && step_q == $past(step_q) && active_q == $past(active_q), "dropped command changed state")

endmodule

[hdl/i2c_byte_master_engine_core.sv]
// Byte-level I2C master engine, top level.
// Each accepted word is either a command (START, STOP, WRITE byte, READ byte) or one bus
// tick that applies one open-drain pin step, MSB first; every word yields one result word
// with the SCL/SDA drive, busy, done, received byte, slave ACK and a rejected flag for a
// command that arrived while busy. A word can be taken every cycle while the result side
// keeps up: the front end and a two-entry queue take input until full while the pin
// sequencer, retiring one word per cycle into its output register unless the result side
// stalls, waits on it. A word passes the queue, then the output register. A START takes 4
// ticks, a STOP 3, a WRITE 27 and a READ 20; pin timing between ticks is up to the issuer.
module i2c_byte_master_engine_core import ibme_pkg::*; #(
  parameter int unsigned QueueDepth = IbmeQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [1:0] command_i,
  input  logic [7:0] tx_byte_i,
  input  logic       more_to_read_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       cmd_done_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_seen_o,
  output logic       cmd_rejected_o
);

  item_t front_item;
  item_t queue_item;
  logic  push;
  logic  queue_ready;
  logic  queue_valid;
  logic  pop;

  ibme_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .command_i      (command_i),
    .tx_byte_i      (tx_byte_i),
    .more_to_read_i (more_to_read_i),
    .sda_in_i       (sda_in_i),
    .push_o         (push),
    .queue_ready_i  (queue_ready),
    .item_o         (front_item)
  );

  ibme_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (queue_ready),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  ibme_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scl_out_o      (scl_out_o),
    .sda_out_o      (sda_out_o),
    .busy_res_o     (busy_res_o),
    .cmd_done_o     (cmd_done_o),
    .rx_byte_o      (rx_byte_o),
    .ack_seen_o     (ack_seen_o),
    .cmd_rejected_o (cmd_rejected_o)
  );

endmodule

[test/ibme_result_checker.sv]
// Checker for the I2C byte master engine: predicts every result word and compares it.
module ibme_result_checker import ibme_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        more_to_read_i,
  input  logic        sda_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        scl_out_i,
  input  logic        sda_out_i,
  input  logic        busy_res_i,
  input  logic        cmd_done_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        ack_seen_i,
  input  logic        cmd_rejected_i,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned finished_o,
  output int unsigned dropped_o,
  output int unsigned mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0] step;
    cmd_e       cmd;
    logic       busy;
    logic [7:0] shreg;
    logic       nack;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
  } engine_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
    logic       rejected;
  } pin_result_t;

  engine_state_t eng;
  pin_result_t   pending_results[$];
  pin_result_t   seen_word;
  pin_result_t   want_word;
  int unsigned   checked_count = 0;
  int unsigned   finished_count = 0;
  int unsigned   dropped_count = 0;
  int unsigned   mismatch_count = 0;

  assign checked_o    = checked_count;
  assign finished_o   = finished_count;
  assign dropped_o    = dropped_count;
  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch({"result word #", $sformatf("%0d", checked_count), " ", name},
                      32'(got), 32'(want));
    end
  endtask

  // One word through the engine: returns the result word it leaves behind.
  function automatic pin_result_t advance_engine(item_kind_e kind, cmd_e cmd, logic [7:0] tx,
                                                 logic more, logic sample);
    pin_result_t r;
    logic [4:0]  s;
    logic        last;
    r    = '0;
    last = 1'b0;
    if (kind == ItemCmd) begin
      if (eng.busy) begin
        r.rejected = 1'b1;
      end else begin
        eng.cmd  = cmd;
        eng.busy = 1'b1;
        eng.step = '0;
        if (cmd == CmdWrite) begin
          eng.shreg = tx;
        end else if (cmd == CmdRead) begin
          eng.shreg = '0;
          eng.nack  = ~more;
        end
      end
    end else if (eng.busy) begin
      s = eng.step;
      case (eng.cmd)
        CmdStart: begin
          if (s == 5'd0) eng.sda = 1'b1;
          else if (s == 5'd1) eng.scl = 1'b1;
          else if (s == 5'd2) eng.sda = 1'b0;
          else begin
            eng.scl = 1'b0;
            last    = 1'b1;
          end
        end
        CmdStop: begin
          if (s == 5'd0) eng.sda = 1'b0;
          else if (s == 5'd1) eng.scl = 1'b1;
          else begin
            eng.sda = 1'b1;
            last    = 1'b1;
          end
        end
        CmdWrite: begin
          if (s < StepWriteAck) begin
            case (int'(s) % 3)
              PhaseData: eng.sda = eng.shreg[7];
              PhaseHigh: eng.scl = 1'b1;
              default: begin
                eng.scl   = 1'b0;
                eng.shreg = {eng.shreg[6:0], 1'b0};
              end
            endcase
          end else if (s == StepWriteAck) begin
            eng.sda = 1'b1;
          end else if (s == StepWriteScl) begin
            eng.scl = 1'b1;
          end else begin
            eng.ack = sample;
            eng.scl = 1'b0;
            last    = 1'b1;
          end
        end
        default: begin
          if (s == 5'd0) begin
            eng.sda = 1'b1;
          end else if (s <= StepReadBits) begin
            if (s[0]) begin
              eng.scl = 1'b1;
            end else begin
              eng.shreg = {eng.shreg[6:0], sample};
              eng.scl   = 1'b0;
            end
          end else if (s == StepReadAns) begin
            eng.sda = eng.nack;
          end else if (s == StepReadScl) begin
            eng.scl = 1'b1;
          end else begin
            eng.scl = 1'b0;
            eng.rx  = eng.shreg;
            last    = 1'b1;
          end
        end
      endcase
      eng.step = s + 5'd1;
      if (last) eng.busy = 1'b0;
    end
    r.scl  = eng.scl;
    r.sda  = eng.sda;
    r.busy = eng.busy;
    r.done = last;
    r.rx   = eng.rx;
    r.ack  = eng.ack;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      eng = '{step: '0, cmd: CmdStart, busy: 1'b0, shreg: '0, nack: 1'b0,
              scl: 1'b1, sda: 1'b1, rx: '0, ack: 1'b1};
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen_word = '{scl: scl_out_i, sda: sda_out_i, busy: busy_res_i, done: cmd_done_i,
                      rx: rx_byte_i, ack: ack_seen_i, rejected: cmd_rejected_i};
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing expected", 32'(seen_word), 32'd0);
        end else begin
          want_word = pending_results.pop_front();
          check_field("scl_out", 8'(seen_word.scl), 8'(want_word.scl));
          check_field("sda_out", 8'(seen_word.sda), 8'(want_word.sda));
          check_field("busy_res", 8'(seen_word.busy), 8'(want_word.busy));
          check_field("cmd_done", 8'(seen_word.done), 8'(want_word.done));
          check_field("rx_byte", seen_word.rx, want_word.rx);
          check_field("ack_seen", 8'(seen_word.ack), 8'(want_word.ack));
          check_field("cmd_rejected", 8'(seen_word.rejected), 8'(want_word.rejected));
          checked_count++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        want_word = advance_engine(item_kind_e'(req_type_i), cmd_e'(command_i), tx_byte_i,
                                   more_to_read_i, sda_in_i);
        if (want_word.done) finished_count++;
        if (want_word.rejected) dropped_count++;
        pending_results.push_back(want_word);
      end
    end
    pending_o <= pending_results.size();
  end

endmodule

[test/i2c_byte_master_engine_core_tb.sv]
// Testbench top for the I2C byte master engine: clock, reset, bus command stimulus, verdict.
module i2c_byte_master_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibme_pkg::*;

  localparam int unsigned TicksStart = 4;
  localparam int unsigned TicksStop  = 3;
  localparam int unsigned TicksWrite = 27;
  localparam int unsigned TicksRead  = 20;
  localparam int unsigned RandWords  = 500;
  localparam int unsigned HoldCycles = 120;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic       req_type;
  logic [1:0] command;
  logic [7:0] tx_byte;
  logic       more_to_read;
  logic       sda_in;
  logic       out_valid;
  logic       out_ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       cmd_done;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       cmd_rejected;

  int unsigned pending;
  int unsigned checked;
  int unsigned finished;
  int unsigned dropped;
  int unsigned mismatches;

  int unsigned words_sent;
  int unsigned seq_words;
  logic        sender_calm;
  logic        hold_req;
  logic        holding;
  logic        hold_done;

  always #5 clk_i = ~clk_i;

  i2c_byte_master_engine_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .req_type_i     (req_type),
    .command_i      (command),
    .tx_byte_i      (tx_byte),
    .more_to_read_i (more_to_read),
    .sda_in_i       (sda_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .scl_out_o      (scl_out),
    .sda_out_o      (sda_out),
    .busy_res_o     (busy_res),
    .cmd_done_o     (cmd_done),
    .rx_byte_o      (rx_byte),
    .ack_seen_o     (ack_seen),
    .cmd_rejected_o (cmd_rejected)
  );

  ibme_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .req_type_i     (req_type),
    .command_i      (command),
    .tx_byte_i      (tx_byte),
    .more_to_read_i (more_to_read),
    .sda_in_i       (sda_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .scl_out_i      (scl_out),
    .sda_out_i      (sda_out),
    .busy_res_i     (busy_res),
    .cmd_done_i     (cmd_done),
    .rx_byte_i      (rx_byte),
    .ack_seen_i     (ack_seen),
    .cmd_rejected_i (cmd_rejected),
    .pending_o      (pending),
    .checked_o      (checked),
    .finished_o     (finished),
    .dropped_o      (dropped),
    .mismatches_o   (mismatches)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one word and returns at the edge that takes it.
  task automatic send_word(input item_kind_e kind, input cmd_e cmd, input logic [7:0] tx,
                           input logic more, input logic sample);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    command      <= cmd;
    tx_byte      <= tx;
    more_to_read <= more;
    sda_in       <= sample;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  // A command followed by its ticks; the slave drives slave_byte on a read and
  // slave_nack in the ACK slot of a write. Now and then a command lands while busy.
  task automatic run_command(input cmd_e cmd, input logic [7:0] tx, input logic more,
                             input logic [7:0] slave_byte, input logic slave_nack);
    int unsigned n;
    logic        sample;
    case (cmd)
      CmdStart: n = TicksStart;
      CmdStop:  n = TicksStop;
      CmdWrite: n = TicksWrite;
      default:  n = TicksRead;
    endcase
    send_word(ItemCmd, cmd, tx, more, 1'($urandom));
    seq_words++;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_word(ItemCmd, cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  1'($urandom));
      end
      sample = 1'($urandom);
      if (cmd == CmdRead && k >= 2 && k <= 16 && k % 2 == 0) sample = slave_byte[8 - k / 2];
      if (cmd == CmdWrite && k == TicksWrite - 1) sample = slave_nack;
      send_word(ItemTick, cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), sample);
      seq_words++;
    end
  endtask

  initial begin
    int unsigned run_len;
    int unsigned gap;
    int unsigned r;
    out_ready = 1'b0;
    holding   = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        holding   = 1'b0;
        hold_done = 1'b1;
      end
      out_ready <= 1'b1;
      run_len = $urandom_range(1, 30);
      repeat (run_len) @(posedge clk_i);
      r = $urandom_range(0, 99);
      gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic did_hold;
    logic did_drain;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    req_type     = ItemCmd;
    command      = CmdStart;
    tx_byte      = '0;
    more_to_read = 1'b0;
    sda_in       = 1'b0;
    words_sent   = 0;
    seq_words    = 0;
    sender_calm  = 1'b0;
    hold_req     = 1'b0;
    did_hold     = 1'b0;
    did_drain    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, each command, extremes, a command dropped while busy
    send_word(ItemTick, CmdStart, 8'hFF, 1'b1, 1'b1);
    run_command(CmdStart, 8'h00, 1'b0, 8'h00, 1'b0);
    run_command(CmdWrite, 8'hFF, 1'b0, 8'h00, 1'b1);
    run_command(CmdRead, 8'hFF, 1'b0, 8'hFF, 1'b0);
    run_command(CmdWrite, 8'h00, 1'b1, 8'hFF, 1'b0);
    run_command(CmdRead, 8'h00, 1'b1, 8'h00, 1'b1);
    send_word(ItemCmd, CmdStop, 8'h00, 1'b0, 1'b0);
    send_word(ItemCmd, CmdWrite, 8'hA5, 1'b1, 1'b1);
    repeat (TicksStop) send_word(ItemTick, CmdRead, 8'h5A, 1'b0, 1'b1);
    send_word(ItemTick, CmdRead, 8'h00, 1'b0, 1'b0);

    seq_words = 0;
    while (seq_words < RandWords) begin
      if (!did_hold && seq_words >= 150) begin
        // receiver stalls long while the sender keeps offering
        in_valid <= 1'b0;
        hold_req = 1'b1;
        do @(posedge clk_i); while (!holding);
        sender_calm = 1'b1;
        run_command(CmdWrite, 8'($urandom), 1'b0, 8'h00, 1'($urandom));
        sender_calm = 1'b0;
        did_hold = 1'b1;
      end
      if (!did_drain && seq_words >= 320) begin
        in_valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
        repeat (4) @(posedge clk_i);
        did_drain = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) sender_calm = ~sender_calm;
      if ($urandom_range(0, 99) < 85) begin
        run_command(cmd_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(item_kind_e'($urandom_range(0, 1)), cmd_e'($urandom_range(0, 3)),
                    8'($urandom), 1'($urandom), 1'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words, checked %0d result words.", words_sent, checked);
    $display("%0d commands finished, %0d dropped while busy, %0d mismatches.",
             finished, dropped, mismatches);
    if (mismatches == 0) begin
      $display("i2c_byte_master_engine_core test passed");
    end else begin
      $display("i2c_byte_master_engine_core test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d result words outstanding.", pending);
    $display("i2c_byte_master_engine_core test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ibme_pkg.sv
hdl/ibme_front.sv
hdl/ibme_queue.sv
hdl/ibme_back.sv
hdl/i2c_byte_master_engine_core.sv
test/ibme_result_checker.sv
test/i2c_byte_master_engine_core_tb.sv
